@@ hw/rtl/rrsm_pkg.sv @@
// Shared types and constants for the request/response stream matcher.
package rrsm_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

   localparam int unsigned STREAM_W = 16;
   localparam int unsigned OPCODE_W = 8;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 8;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_SOLITARY_OPCODE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SUBSTITUTE_OPCODE = CSR_IDX_W'(1);

   localparam logic [OPCODE_W-1:0] SOLITARY_OPCODE_RESET   = OPCODE_W'(12);
   localparam logic [OPCODE_W-1:0] SUBSTITUTE_OPCODE_RESET = OPCODE_W'(11);

   typedef enum logic [1:0] {
      STATUS_MATCHED   = 2'd0,
      STATUS_SOLITARY  = 2'd1,
      STATUS_UNMATCHED = 2'd2,
      STATUS_DROPPED   = 2'd3
   } match_status_type;

   typedef struct packed {
      logic [STREAM_W-1:0] stream;
      logic [OPCODE_W-1:0] opcode;
      logic [TIME_W-1:0]   stamp;
   } entry_type;

   // Controller -> datapath
   typedef struct packed {
      logic             capture;
      logic             push;
      logic             start_scan;
      logic             read_entry;
      logic             advance_scan;
      logic             mark_hit;
      logic             retire_one;
      logic             set_status;
      match_status_type status_code;
      logic             load_out;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic is_resp;
      logic is_solitary;
      logic queue_full;
      logic queue_empty;
      logic hit;
      logic scan_last;
      logic head_consumed;
      logic out_free;
   } sts_type;

endpackage

@@ hw/rtl/rrsm_datapath.sv @@
// Queue storage, pointers, config registers and result register of the matcher.
module rrsm_datapath import rrsm_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_type,
   input  logic [STREAM_W-1:0]   req_stream_tag,
   input  logic [OPCODE_W-1:0]   req_frame_opcode,
   input  logic [TIME_W-1:0]     req_frame_time,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_match_status,
   output logic [STREAM_W-1:0]   rsp_out_stream,
   output logic [OPCODE_W-1:0]   rsp_out_req_opcode,
   output logic [TIME_W-1:0]     rsp_out_req_time,
   output logic [OPCODE_W-1:0]   rsp_out_resp_opcode,
   output logic [TIME_W-1:0]     rsp_out_resp_time
);

   localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_entry_ff;

   logic [QUEUE_DEPTH-1:0] consumed_ff, consumed_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [IDX_W-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [OCC_W-1:0]       scan_cnt_ff, scan_cnt_in;

   logic                   is_resp_ff;
   logic [STREAM_W-1:0]    tag_ff;
   logic [OPCODE_W-1:0]    opcode_ff;
   logic [TIME_W-1:0]      stamp_ff;
   match_status_type       status_ff;

   logic [OPCODE_W-1:0]    sol_opcode_ff, sub_opcode_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             match_status_ff;
   logic [STREAM_W-1:0]    out_stream_ff;
   logic [OPCODE_W-1:0]    out_req_opcode_ff, out_req_opcode_in;
   logic [TIME_W-1:0]      out_req_time_ff, out_req_time_in;
   logic [OPCODE_W-1:0]    out_resp_opcode_ff, out_resp_opcode_in;
   logic [TIME_W-1:0]      out_resp_time_ff, out_resp_time_in;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   // ---------------- status ----------------
   assign sts.is_resp       = is_resp_ff;
   assign sts.is_solitary   = (opcode_ff == sol_opcode_ff);
   assign sts.queue_full    = (occ_ff == FULL_OCC);
   assign sts.queue_empty   = (occ_ff == '0);
   assign sts.hit           = !consumed_ff[scan_ptr_ff] && (rd_entry_ff.stream == tag_ff);
   assign sts.scan_last     = ((scan_cnt_ff + 1'b1) == occ_ff);
   assign sts.head_consumed = (occ_ff != '0) && consumed_ff[head_ff];
   assign sts.out_free      = !rsp_valid_ff || !rsp_stall;

   // ---------------- capture and config ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_resp_ff <= req_type;
         tag_ff     <= req_stream_tag;
         opcode_ff  <= req_frame_opcode;
         stamp_ff   <= req_frame_time;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sol_opcode_ff <= SOLITARY_OPCODE_RESET;
         sub_opcode_ff <= SUBSTITUTE_OPCODE_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_SOLITARY_OPCODE) begin
            sol_opcode_ff <= csr_data;
         end else if (csr_index == CSR_SUBSTITUTE_OPCODE) begin
            sub_opcode_ff <= csr_data;
         end
      end
   end

   // ---------------- queue memory ----------------
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= '{stream: tag_ff, opcode: opcode_ff, stamp: stamp_ff};
      end
      if (cmd.read_entry) begin
         rd_entry_ff <= mem[scan_ptr_ff];
      end
   end

   // ---------------- pointers and consumed flags ----------------
   always_comb begin
      consumed_in = consumed_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      scan_ptr_in = scan_ptr_ff;
      scan_cnt_in = scan_cnt_ff;
      if (cmd.push) begin
         consumed_in[tail_ff] = 1'b0;
         tail_in              = wrap_inc(tail_ff);
         occ_in               = occ_ff + 1'b1;
      end
      if (cmd.start_scan) begin
         scan_ptr_in = head_ff;
         scan_cnt_in = '0;
      end
      if (cmd.advance_scan) begin
         scan_ptr_in = wrap_inc(scan_ptr_ff);
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
      if (cmd.mark_hit) begin
         consumed_in[scan_ptr_ff] = 1'b1;
      end
      if (cmd.retire_one) begin
         consumed_in[head_ff] = 1'b0;
         head_in              = wrap_inc(head_ff);
         occ_in               = occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         consumed_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         occ_ff      <= '0;
         scan_ptr_ff <= '0;
         scan_cnt_ff <= '0;
      end else begin
         consumed_ff <= consumed_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         occ_ff      <= occ_in;
         scan_ptr_ff <= scan_ptr_in;
         scan_cnt_ff <= scan_cnt_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      unique case (status_ff)
         STATUS_MATCHED: begin
            out_req_opcode_in  = rd_entry_ff.opcode;
            out_req_time_in    = rd_entry_ff.stamp;
            out_resp_opcode_in = opcode_ff;
            out_resp_time_in   = stamp_ff;
         end
         STATUS_SOLITARY: begin
            out_req_opcode_in  = sub_opcode_ff;
            out_req_time_in    = stamp_ff;
            out_resp_opcode_in = opcode_ff;
            out_resp_time_in   = stamp_ff;
         end
         STATUS_UNMATCHED: begin
            out_req_opcode_in  = '0;
            out_req_time_in    = '0;
            out_resp_opcode_in = opcode_ff;
            out_resp_time_in   = stamp_ff;
         end
         default: begin
            // dropped request: request fields echo the frame
            out_req_opcode_in  = opcode_ff;
            out_req_time_in    = stamp_ff;
            out_resp_opcode_in = '0;
            out_resp_time_in   = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         match_status_ff    <= status_ff;
         out_stream_ff      <= tag_ff;
         out_req_opcode_ff  <= out_req_opcode_in;
         out_req_time_ff    <= out_req_time_in;
         out_resp_opcode_ff <= out_resp_opcode_in;
         out_resp_time_ff   <= out_resp_time_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_match_status    = match_status_ff;
   assign rsp_out_stream      = out_stream_ff;
   assign rsp_out_req_opcode  = out_req_opcode_ff;
   assign rsp_out_req_time    = out_req_time_ff;
   assign rsp_out_resp_opcode = out_resp_opcode_ff;
   assign rsp_out_resp_time   = out_resp_time_ff;

endmodule

@@ hw/rtl/rrsm_controller.sv @@
// Sequencing state machine of the matcher: decode, tag search, head retirement, emit.
module rrsm_controller import rrsm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_COMPARE,
      ST_RETIRE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      cmd         = '0;
      cmd.status_code = STATUS_MATCHED;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (!sts.is_resp) begin
               if (sts.queue_full) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_DROPPED;
                  state_in        = ST_EMIT;
               end else begin
                  cmd.push = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (sts.is_solitary) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_SOLITARY;
               state_in        = ST_EMIT;
            end else if (sts.queue_empty) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_UNMATCHED;
               state_in        = ST_EMIT;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_entry = 1'b1;
            state_in       = ST_COMPARE;
         end
         ST_COMPARE: begin
            priority if (sts.hit) begin
               cmd.mark_hit    = 1'b1;
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_MATCHED;
               state_in        = ST_RETIRE;
            end else if (sts.scan_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_UNMATCHED;
               state_in        = ST_RETIRE;
            end else begin
               cmd.advance_scan = 1'b1;
               state_in         = ST_READ;
            end
         end
         ST_RETIRE: begin
            if (sts.head_consumed) begin
               cmd.retire_one = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

endmodule

@@ hw/rtl/request_response_stream_matcher_top.sv @@
// Top level of the request/response stream matcher.
//
// Request channel (req_*): frames with a type bit (0 request, 1 response),
// stream tag, opcode and capture time. An item is taken when req_valid is
// high and req_stall is low. Requests go into an ordered queue of QUEUE_DEPTH
// entries; a response takes the oldest unconsumed request of its stream.
// Result channel (rsp_*): at most one record per item, held in an output
// register until taken (rsp_valid high, rsp_stall low). While a record waits
// the block still accepts and works on the next item; it waits to emit only when a
// second record is ready and the register is still full.
// Config channel (csr_*): always ready; index 0 sets the event opcode,
// index 1 the substitute request opcode, other indexes are ignored.
// Work per item: a request is captured and stored; an event, a dropped request
// or a response on an empty queue is captured, decoded and emitted; other
// responses run a tag search (one registered queue-memory read and one compare
// per examined entry), retire consumed head entries, one per cycle, and emit.
// Reset empties the queue and loads opcode defaults 12 and 11; no clear pass.
module request_response_stream_matcher_top import rrsm_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [STREAM_W-1:0]   req_stream_tag,
   input  logic [OPCODE_W-1:0]   req_frame_opcode,
   input  logic [TIME_W-1:0]     req_frame_time,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_match_status,
   output logic [STREAM_W-1:0]   rsp_out_stream,
   output logic [OPCODE_W-1:0]   rsp_out_req_opcode,
   output logic [TIME_W-1:0]     rsp_out_req_time,
   output logic [OPCODE_W-1:0]   rsp_out_resp_opcode,
   output logic [TIME_W-1:0]     rsp_out_resp_time,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   rrsm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rrsm_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_type            (req_type),
      .req_stream_tag      (req_stream_tag),
      .req_frame_opcode    (req_frame_opcode),
      .req_frame_time      (req_frame_time),
      .csr_valid           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_match_status    (rsp_match_status),
      .rsp_out_stream      (rsp_out_stream),
      .rsp_out_req_opcode  (rsp_out_req_opcode),
      .rsp_out_req_time    (rsp_out_req_time),
      .rsp_out_resp_opcode (rsp_out_resp_opcode),
      .rsp_out_resp_time   (rsp_out_resp_time)
   );

   // an accepted item always keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel not stalled after an accepted item");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !sts.queue_full)
      else $error("push into a full queue");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result register overwritten while still held");

   a_empty_full_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sts.queue_empty && sts.queue_full))
      else $error("queue reported both empty and full");

endmodule
